// ----- rtl/core/msh_pkg.sv -----
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types, codes and widths of the mean-shift window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package msh_pkg;

  // store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 8;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // stream widths
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;

  // accumulator widths
  localparam int SQR_W  = 17;
  localparam int TERM_W = SQR_W + PIXEL_BITS;
  localparam int WSUM_W = 44;
  localparam int XSUM_W = 53;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INIT_OUT = 3'd1;
  localparam logic [2:0] ST_LEFT     = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_CAP      = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_PAD_W   = 2'd0;
  localparam logic [1:0] REG_PAD_H   = 2'd1;
  localparam logic [1:0] REG_PAD_DIR = 2'd2;
  localparam logic [1:0] REG_MAX_IT  = 2'd3;

  // input kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRACK = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_WIN, S_CHK, S_SQR, S_INIT, S_SCAN, S_TEST,
    S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_MOVE, S_CHK2, S_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       pad;
    logic       win;
    logic       chk;
    logic       sqr;
    logic       scan_init;
    logic       iter_inc;
    logic       div_start;
    logic       div_sel;
    logic       move;
    logic       res_load;
    logic [2:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic win_bad;
    logic wsum_zero;
    logic small_move;
    logic cap_hit;
    logic scan_done;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/msh_div.sv -----
// ----------------------------------------------------------------------------
// msh_div
// Restoring divider for the centroid; quotient is known to fit 9 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module msh_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [msh_pkg::XSUM_W-1:0] num_i,
  input  wire logic [msh_pkg::WSUM_W-1:0] den_i,
  output logic                           done_o,
  output logic [8:0]                     quo_o
);
  import msh_pkg::*;

  logic [XSUM_W-1:0] rem_q, rem_d, trial;
  logic [WSUM_W-1:0] den_q, den_d;
  logic [3:0]        step_q, step_d;
  logic [8:0]        quo_q, quo_d;
  logic              run_q, run_d, done_q, done_d;
  logic              ge;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial  = XSUM_W'({9'd0, den_q} << step_q);
    ge     = rem_q >= trial;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    quo_d  = quo_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = den_i;
      step_d = 4'd8;
      quo_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (ge) rem_d = rem_q - trial;
      quo_d = {quo_q[7:0], ge};
      if (step_q == 4'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/msh_ctrl.sv -----
// ----------------------------------------------------------------------------
// msh_ctrl
// Sequencer of the tracker: handshakes, setup, scan, divide and result.
// ----------------------------------------------------------------------------
`default_nettype none

module msh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_action_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output msh_pkg::cmd_t      cmd_o,
  input  wire msh_pkg::sts_t sts_i
);
  import msh_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    code_d        = code_q;
    cmd_o         = '0;
    cmd_o.res_code = code_q;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.pad = 1'b1;
        state_d   = S_WIN;
      end
      S_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (sts_i.win_bad) begin
          code_d  = ST_INIT_OUT;
          state_d = S_EMIT;
        end else begin
          cmd_o.chk = 1'b1;
          state_d   = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = S_INIT;
      end
      S_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_TEST;
      end
      S_TEST: begin
        cmd_o.iter_inc = 1'b1;
        if (sts_i.wsum_zero) begin
          code_d  = ST_ZERO;
          state_d = S_EMIT;
        end else begin
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITX;
      end
      S_WAITX: begin
        if (sts_i.div_done) state_d = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = S_WAITY;
      end
      S_WAITY: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_CHK2;
      end
      S_CHK2: begin
        if (sts_i.win_bad) begin
          code_d  = ST_LEFT;
          state_d = S_EMIT;
        end else if (sts_i.small_move) begin
          code_d  = ST_OK;
          state_d = S_EMIT;
        end else if (sts_i.cap_hit) begin
          code_d  = ST_CAP;
          state_d = S_EMIT;
        end else begin
          state_d = S_INIT;
        end
      end
      S_EMIT: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/msh_dp.sv -----
// ----------------------------------------------------------------------------
// msh_dp
// Datapath: pixel store, window setup, weighted scan pipeline and result.
// ----------------------------------------------------------------------------
`default_nettype none

module msh_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [10:0]                    cfg_data_i,
  input  wire logic [msh_pkg::IN_DATA_W-1:0]  in_data_i,
  input  wire msh_pkg::cmd_t                  cmd_i,
  output msh_pkg::sts_t                       sts_o,
  output logic [msh_pkg::OUT_DATA_W-1:0]      out_data_o
);
  import msh_pkg::*;

  // input fields
  logic [15:0] f_index;
  logic [7:0]  f_value;
  assign f_index = in_data_i[15:0];
  assign f_value = in_data_i[23:16];

  // configuration registers
  logic [10:0]       psw_q, psh_q;
  logic signed [1:0] dir_q;
  logic [7:0]        maxit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psw_q   <= 11'd128;
      psh_q   <= 11'd128;
      dir_q   <= 2'sd1;
      maxit_q <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAD_W:   psw_q   <= cfg_data_i;
        REG_PAD_H:   psh_q   <= cfg_data_i;
        REG_PAD_DIR: dir_q   <= cfg_data_i[1:0];
        REG_MAX_IT:  maxit_q <= cfg_data_i[7:0];
        default:     psw_q   <= psw_q;
      endcase
    end
  end

  // pixel store
  logic [PIXEL_BITS-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
  logic [ADDR_W-1:0]     addr_q;
  logic [PIXEL_BITS-1:0] pix1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[f_index[ADDR_W-1:0]] <= f_value[PIXEL_BITS-1:0];
    pix1_q <= mem[addr_q];
  end

  // captured track item
  logic [8:0]  rw_q, rh_q, pw_q, ph_q;
  logic [11:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rw_q <= in_data_i[32:24];
      rh_q <= in_data_i[41:33];
      px_q <= in_data_i[53:42];
      py_q <= in_data_i[65:54];
      pw_q <= in_data_i[74:66];
      ph_q <= in_data_i[83:75];
    end
  end

  // padding
  logic [19:0]        padw_prod, padh_prod;
  logic [11:0]        dw_q, dh_q;
  logic signed [9:0]  bx_q, by_q, bx_diff, by_diff;
  logic signed [13:0] dxp, dyp;
  logic signed [13:0] dx_q, dy_q;
  logic signed [14:0] wx_q, wy_q;
  logic [12:0]        ww_q, wh_q;

  assign padw_prod = pw_q * psw_q;
  assign padh_prod = ph_q * psh_q;
  assign bx_diff   = $signed({1'b0, rw_q}) - $signed({1'b0, pw_q});
  assign by_diff   = $signed({1'b0, rh_q}) - $signed({1'b0, ph_q});
  assign dxp       = dir_q * $signed({1'b0, dw_q});
  assign dyp       = dir_q * $signed({1'b0, dh_q});

  // window geometry and centre
  logic [8:0]         cx_q, cy_q, qx_q, qy_q;
  logic [17:0]        sqw_q, sqh_q;
  logic [SQR_W-1:0]   sqr_q;
  logic [18:0]        sq_sum;
  logic signed [10:0] mx, my;
  logic signed [10:0] mx_q, my_q;
  logic [8:0]         iter_q;

  assign sq_sum = {1'b0, sqw_q} + {1'b0, sqh_q};
  assign mx     = $signed({2'b0, qx_q}) - $signed({2'b0, cx_q});
  assign my     = $signed({2'b0, qy_q}) - $signed({2'b0, cy_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.pad) begin
      dw_q <= padw_prod[19:8];
      dh_q <= padh_prod[19:8];
      bx_q <= bx_diff >>> 1;
      by_q <= by_diff >>> 1;
    end
    if (cmd_i.win) begin
      dx_q <= dxp >>> 1;
      dy_q <= dyp >>> 1;
      wx_q <= 15'(bx_q) + 15'(dxp >>> 1);
      wy_q <= 15'(by_q) + 15'(dyp >>> 1);
      ww_q <= {4'd0, pw_q} + {1'b0, dw_q};
      wh_q <= {4'd0, ph_q} + {1'b0, dh_q};
    end
    if (cmd_i.chk) begin
      cx_q  <= wx_q[8:0] + ww_q[9:1];
      cy_q  <= wy_q[8:0] + wh_q[9:1];
      sqw_q <= ww_q[8:0] * ww_q[8:0];
      sqh_q <= wh_q[8:0] * wh_q[8:0];
    end
    if (cmd_i.sqr) sqr_q <= sq_sum[18:2];
    if (cmd_i.move) begin
      mx_q <= mx;
      my_q <= my;
      wx_q <= wx_q + 15'(mx);
      wy_q <= wy_q + 15'(my);
      cx_q <= qx_q;
      cy_q <= qy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.chk) begin
      iter_q <= '0;
    end else if (cmd_i.iter_inc) begin
      iter_q <= iter_q + 9'd1;
    end
  end

  // window bounds test
  logic signed [16:0] right_e, bottom_e;
  assign right_e  = 17'(wx_q) + $signed({4'd0, ww_q});
  assign bottom_e = 17'(wy_q) + $signed({4'd0, wh_q});

  // move test
  logic [21:0] mx2, my2;
  logic [22:0] mv2;
  logic [8:0]  cap;
  assign mx2 = 22'(mx_q * mx_q);
  assign my2 = 22'(my_q * my_q);
  assign mv2 = {1'b0, mx2} + {1'b0, my2};
  assign cap = (maxit_q == 8'd0) ? 9'd256 : {1'b0, maxit_q};

  // scan address generator
  logic              act_q;
  logic [8:0]        x_q, y_q, x_last, y_last;
  logic [ADDR_W-1:0] row_q;
  logic [17:0]       row_start;

  assign x_last    = wx_q[8:0] + ww_q[8:0] - 9'd1;
  assign y_last    = wy_q[8:0] + wh_q[8:0] - 9'd1;
  assign row_start = wy_q[8:0] * rw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      act_q <= (ww_q != '0) && (wh_q != '0);
    end else if (act_q && x_q == x_last && y_q == y_last) begin
      act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      x_q    <= wx_q[8:0];
      y_q    <= wy_q[8:0];
      row_q  <= ADDR_W'(row_start) + ADDR_W'(wx_q[8:0]);
      addr_q <= ADDR_W'(row_start) + ADDR_W'(wx_q[8:0]);
    end else if (act_q) begin
      if (x_q == x_last) begin
        x_q    <= wx_q[8:0];
        y_q    <= y_q + 9'd1;
        row_q  <= row_q + ADDR_W'(rw_q);
        addr_q <= row_q + ADDR_W'(rw_q);
      end else begin
        x_q    <= x_q + 9'd1;
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  // weighting pipeline: read, distance, term, products, accumulate
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [8:0]         x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic [PIXEL_BITS-1:0] pix2_q;
  logic signed [10:0] ex, ey;
  logic [21:0]        ex2, ey2;
  logic [22:0]        d2, d2_q;
  logic [SQR_W-1:0]   diff;
  logic [TERM_W-1:0]  term3_q, term4_q;
  logic [TERM_W+8:0]  px4_q, py4_q;
  logic [WSUM_W-1:0]  wsum_q;
  logic [XSUM_W-1:0]  xsum_q, ysum_q;

  assign ex   = $signed({2'b0, cx_q}) - $signed({2'b0, x1_q});
  assign ey   = $signed({2'b0, cy_q}) - $signed({2'b0, y1_q});
  assign ex2  = 22'(ex * ex);
  assign ey2  = 22'(ey * ey);
  assign d2   = {1'b0, ex2} + {1'b0, ey2};
  assign diff = (d2_q < {6'd0, sqr_q}) ? sqr_q - d2_q[SQR_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= x_q;
    y1_q    <= y_q;
    x2_q    <= x1_q;
    y2_q    <= y1_q;
    d2_q    <= d2;
    pix2_q  <= pix1_q;
    x3_q    <= x2_q;
    y3_q    <= y2_q;
    term3_q <= diff * pix2_q;
    term4_q <= term3_q;
    px4_q   <= x3_q * term3_q;
    py4_q   <= y3_q * term3_q;
    if (cmd_i.scan_init) begin
      wsum_q <= '0;
      xsum_q <= '0;
      ysum_q <= '0;
    end else if (v4_q) begin
      wsum_q <= wsum_q + WSUM_W'(term4_q);
      xsum_q <= xsum_q + XSUM_W'(px4_q);
      ysum_q <= ysum_q + XSUM_W'(py4_q);
    end
  end

  // shared centroid divider
  logic       div_done;
  logic [8:0] quo;

  msh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_sel ? ysum_q : xsum_q),
    .den_i   (wsum_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (cmd_i.div_sel) qy_q <= quo;
      else               qx_q <= quo;
    end
  end

  // status back to the sequencer
  always_comb begin
    sts_o.win_bad    = wx_q < 0 || wy_q < 0 ||
                       right_e >= $signed({8'd0, rw_q}) ||
                       bottom_e >= $signed({8'd0, rh_q});
    sts_o.wsum_zero  = wsum_q == '0;
    sts_o.small_move = mv2 <= 23'd4;
    sts_o.cap_hit    = iter_q >= cap;
    sts_o.scan_done  = !act_q && !v1_q && !v2_q && !v3_q && !v4_q;
    sts_o.div_done   = div_done;
  end

  // result register
  logic [2:0]         r_st_q;
  logic [13:0]        r_mx_q, r_my_q;
  logic [8:0]         r_mw_q, r_mh_q;
  logic signed [15:0] meas_x, meas_y;

  assign meas_x = $signed({4'd0, px_q}) - 16'(bx_q) + 16'(wx_q) - 16'(dx_q);
  assign meas_y = $signed({4'd0, py_q}) - 16'(by_q) + 16'(wy_q) - 16'(dy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      r_st_q <= cmd_i.res_code;
      r_mw_q <= pw_q;
      r_mh_q <= ph_q;
      if (cmd_i.res_code == ST_OK) begin
        r_mx_q <= meas_x[13:0];
        r_my_q <= meas_y[13:0];
      end else begin
        r_mx_q <= '0;
        r_my_q <= '0;
      end
    end
  end

  assign out_data_o = {7'd0, r_mh_q, r_mw_q, r_my_q, r_mx_q, r_st_q};

endmodule

`default_nettype wire

// ----- rtl/core/meanshift_window_tracker.sv -----
// ----------------------------------------------------------------------------
// meanshift_window_tracker
// Mean-shift box tracker with an Epanechnikov kernel over a loaded region.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis beats with tuser 0 write one pixel into the store: one beat a
//   cycle, no result. Every pixel that a track reads must be loaded first.
//   A beat with tuser 1 starts a track; the block then takes no beat until
//   the result beat is registered on m_axis.
//   Track flow: the setup steps pad, window, check and square, then per
//   mean-shift iteration the scan start, a scan of ww*wh pixels (one pixel
//   a cycle from the single store read port), the pipeline drain, two
//   divides and the move test, then the result enters the output register.
//   The iteration count is bounded by max_iterations.
//   Configuration writes on cfg_* are taken in every cycle (cfg_ready_o is
//   always high) and must only be issued while the block is idle.
//   Reset loads the register defaults and clears all control state; the
//   pixel store holds no reset value.
//   A stalled m_axis beat holds; loads are still taken meanwhile, and a
//   finished track waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module meanshift_window_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // tdata: pixel_index, pixel_value, region_width, region_height,
  //        pred_x, pred_y, pred_w, pred_h, zero pad
  input  wire logic [msh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action
  input  wire logic                           s_axis_tuser,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: status, meas_x, meas_y, meas_w, meas_h, zero pad
  output logic [msh_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [10:0]                    cfg_data_i
);
  import msh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  msh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  msh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
